// File: rtl/core/linear_probe_hash_insert_assert.svh
// Assertion macros for the linear probe hash insert block
`ifndef LINEAR_PROBE_HASH_INSERT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_ASSERT_SVH
`ifndef SYNTHESIS
`define LPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LPH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LPH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Types and constants shared by the hash table front end and back end.
// ----------------------------------------------------------------------------
package lph_pkg;
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [2:0] ST_NEW   = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FAIL  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;

  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
  localparam logic [63:0] EMPTY_SLOT = '1;
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef enum logic [1:0] {OP_CLEAR, OP_INSERT, OP_READ} op_t;

  typedef struct packed {
    op_t         op;
    logic [62:0] key;
    logic [63:0] hash;
    logic [9:0]  rslot;
    logic        fin;
  } job_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_M1A, FE_M1B, FE_M2A, FE_M2B, FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE, BE_WIPE, BE_PROBE, BE_WAIT, BE_CHECK, BE_OUT
  } be_state_t;
endpackage

// File: rtl/core/linear_probe_hash_insert.sv
// The back end sets how fast items complete; front hashing of the next key
// overlaps probing. The 32x32 multiplies set the hashing cost, and the slot
// memory's registered read port sets the per-probe cost.
// Reset: synchronous, rst_n low; then a sweep fills every slot of the slot
// memory with all ones before the first item leaves the queue.
// ----------------------------------------------------------------------------
// linear_probe_hash_insert
// Open-addressing key table with splitmix64 hashing and linear probing.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,  // mode[1:0], key_value[64:2], read_slot[74:65]
  input  logic         in_tlast,  // final_key
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata, // status[2:0], placed_slot[12:3],
                                  // entry_total[23:13], slot_contents[87:24]
  output logic         out_tuser, // failed_flag
  output logic         out_tlast, // build_done
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [3:0]  lg_r;
  logic [10:0] pl_r;
  logic        push, q_full, pop, q_ne;
  lph_pkg::job_t pjob, hjob;
  logic [2:0]  st;
  logic [9:0]  ps;
  logic [10:0] tot;
  logic [63:0] ct;
  logic        fl, dn;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= 4'd10; pl_r <= 11'd8;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == 3'd0) lg_r <= cfg_pwdata[3:0];
      if (cfg_paddr == 3'd4) pl_r <= cfg_pwdata[10:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {28'd0, lg_r} :
                      (cfg_paddr == 3'd4) ? {21'd0, pl_r} : 32'd0;

  lph_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tdata[1:0]), .in_key(in_tdata[64:2]), .in_rslot(in_tdata[74:65]),
    .in_fin(in_tlast), .push(push), .push_job(pjob), .q_full(q_full));

  lph_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(pjob), .full(q_full),
    .pop(pop), .not_empty(q_ne), .head(hjob));

  lph_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_job(hjob), .pop(pop),
    .log2_cap(lg_r), .probe_limit(pl_r), .out_valid(out_tvalid),
    .out_ready(out_tready), .o_status(st), .o_slot(ps), .o_total(tot),
    .o_contents(ct), .o_failed(fl), .o_done(dn));

  assign out_tdata = {ct, tot, ps, st};
  assign out_tuser = fl;
  assign out_tlast = dn;
endmodule

// File: rtl/core/lph_front.sv
// ----------------------------------------------------------------------------
// lph_front
// Accepts items, hashes insert keys with the splitmix64 finalizer using 32x32
// multipliers, and pushes jobs to the queue.
// ----------------------------------------------------------------------------
module lph_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_mode,
  input  logic [62:0]    in_key,
  input  logic [9:0]     in_rslot,
  input  logic           in_fin,
  output logic           push,
  output lph_pkg::job_t  push_job,
  input  logic           q_full
);
  lph_pkg::fe_state_t state_r, state_nxt;
  lph_pkg::job_t      job_r, job_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] c;

  assign prod = {32'd0, ma} * {32'd0, mb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lph_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r <= job_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    push_job  = job_r;
    c  = (state_r == lph_pkg::FE_M1A || state_r == lph_pkg::FE_M1B) ?
         lph_pkg::MIX_C1 : lph_pkg::MIX_C2;
    ma = x_r[31:0];
    mb = c[31:0];
    case (state_r)
      lph_pkg::FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          job_nxt.key   = in_key;
          job_nxt.rslot = in_rslot;
          job_nxt.fin   = in_fin;
          job_nxt.hash  = '0;
          x_nxt = {1'b0, in_key} ^ ({1'b0, in_key} >> 30);
          case (in_mode)
            lph_pkg::MODE_CLEAR: begin
              job_nxt.op = lph_pkg::OP_CLEAR;
              state_nxt  = lph_pkg::FE_PUSH;
            end
            lph_pkg::MODE_INSERT: begin
              job_nxt.op = lph_pkg::OP_INSERT;
              state_nxt  = lph_pkg::FE_M1A;
            end
            default: begin
              job_nxt.op = lph_pkg::OP_READ;
              state_nxt  = lph_pkg::FE_PUSH;
            end
          endcase
        end
      end
      lph_pkg::FE_M1A, lph_pkg::FE_M2A: begin
        // low x low; both cross terms are added in the B state
        acc_nxt   = prod;
        state_nxt = (state_r == lph_pkg::FE_M1A) ? lph_pkg::FE_M1B : lph_pkg::FE_M2B;
      end
      lph_pkg::FE_M1B, lph_pkg::FE_M2B: begin
        // cross terms, 32 bits each; only low halves matter
        acc_nxt = acc_r + {(x_r[31:0] * c[63:32]) + (x_r[63:32] * c[31:0]), 32'd0};
        if (state_r == lph_pkg::FE_M1B) begin
          x_nxt     = acc_nxt ^ (acc_nxt >> 27);
          state_nxt = lph_pkg::FE_M2A;
        end else begin
          job_nxt.hash = acc_nxt ^ (acc_nxt >> 31);
          state_nxt    = lph_pkg::FE_PUSH;
        end
      end
      lph_pkg::FE_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = lph_pkg::FE_IDLE;
        end
      end
      default: state_nxt = lph_pkg::FE_IDLE;
    endcase
  end
endmodule

// File: rtl/core/lph_queue.sv
// ----------------------------------------------------------------------------
// lph_queue
// Two-entry job queue between front end and back end.
// ----------------------------------------------------------------------------
module lph_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lph_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lph_pkg::job_t head
);
  lph_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= push_job;
  end
endmodule

// File: rtl/core/lph_back.sv
// ----------------------------------------------------------------------------
// lph_back
// Executes jobs against the slot memory: clearing sweep, linear probe insert
// and slot read. Holds the result in an output register.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_insert_assert.svh"
module lph_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lph_pkg::job_t q_job,
  output logic          pop,
  input  logic [3:0]    log2_cap,
  input  logic [10:0]   probe_limit,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    o_status,
  output logic [9:0]    o_slot,
  output logic [10:0]   o_total,
  output logic [63:0]   o_contents,
  output logic          o_failed,
  output logic          o_done
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MAXLG = AW;

  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  lph_pkg::be_state_t state_r, state_nxt;
  lph_pkg::job_t job_r, job_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [AW:0]   wipe_r, wipe_nxt;
  logic [10:0]   left_r, left_nxt;
  logic [10:0]   cnt_r, cnt_nxt;
  logic          fail_r, fail_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [9:0]    ps_r, ps_nxt;
  logic [63:0]   ct_r, ct_nxt;
  logic          dn_r, dn_nxt;
  logic [AW-1:0] mask;
  logic [4:0]    lg;
  logic          clr_pend_r;

  always_comb begin
    lg = {1'b0, log2_cap};
    if (lg < 5'd1) lg = 5'd1;
    if (lg > 5'(MAXLG)) lg = 5'(MAXLG);
    mask = AW'(({{(AW){1'b0}}, 1'b1} << lg) - 1'b1);
    if (lg >= 5'(AW)) mask = '1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lph_pkg::BE_WIPE;
      wipe_r  <= '0;
      cnt_r   <= '0;
      fail_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wipe_r  <= wipe_nxt;
      cnt_r   <= cnt_nxt;
      fail_r  <= fail_nxt;
      ov_r    <= ov_nxt;
    end
    job_r  <= job_nxt;
    slot_r <= slot_nxt;
    left_r <= left_nxt;
    st_r   <= st_nxt;
    ps_r   <= ps_nxt;
    ct_r   <= ct_nxt;
    dn_r   <= dn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_pend_r <= 1'b0;
    else if (pop && q_job.op == lph_pkg::OP_CLEAR) clr_pend_r <= 1'b1;
    else if (state_r == lph_pkg::BE_OUT) clr_pend_r <= 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r; slot_nxt = slot_r; wipe_nxt = wipe_r; left_nxt = left_r;
    cnt_nxt = cnt_r; fail_nxt = fail_r; ov_nxt = ov_r;
    st_nxt = st_r; ps_nxt = ps_r; ct_nxt = ct_r; dn_nxt = dn_r;
    pop = 1'b0; we = 1'b0; waddr = slot_r; wdata = lph_pkg::EMPTY_SLOT;
    raddr = slot_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      lph_pkg::BE_WIPE: begin
        we = 1'b1;
        waddr = wipe_r[AW-1:0];
        wipe_nxt = wipe_r + 1'b1;
        if (wipe_r == (AW+1)'(TABLE_DEPTH - 1)) begin
          wipe_nxt  = '0;
          // the sweep after reset gives no result, a clear job does
          state_nxt = clr_pend_r ? lph_pkg::BE_OUT : lph_pkg::BE_IDLE;
        end
      end
      lph_pkg::BE_IDLE: begin
        if (q_valid && !ov_r) begin
          pop = 1'b1;
          job_nxt = q_job;
          dn_nxt = q_job.fin;
          ct_nxt = '0;
          ps_nxt = '0;
          left_nxt = (probe_limit == 11'd0) ? 11'd1 : probe_limit;
          case (q_job.op)
            lph_pkg::OP_CLEAR: begin
              cnt_nxt = '0; fail_nxt = 1'b0;
              st_nxt = lph_pkg::ST_CLEAR;
              state_nxt = lph_pkg::BE_WIPE;
            end
            lph_pkg::OP_INSERT: begin
              slot_nxt = q_job.hash[AW-1:0] & mask;
              state_nxt = lph_pkg::BE_PROBE;
            end
            default: begin
              slot_nxt = AW'(q_job.rslot);
              state_nxt = lph_pkg::BE_PROBE;
            end
          endcase
        end
      end
      lph_pkg::BE_PROBE: state_nxt = lph_pkg::BE_WAIT;
      lph_pkg::BE_WAIT: state_nxt = lph_pkg::BE_CHECK;
      lph_pkg::BE_CHECK: begin
        state_nxt = lph_pkg::BE_OUT;
        ps_nxt = 10'(slot_r);
        if (job_r.op == lph_pkg::OP_READ) begin
          st_nxt = lph_pkg::ST_READ;
          ct_nxt = rd_r;
        end else if (rd_r == lph_pkg::EMPTY_SLOT) begin
          we = 1'b1; wdata = {1'b0, job_r.key};
          if (cnt_r != lph_pkg::COUNT_MAX) cnt_nxt = cnt_r + 11'd1;
          st_nxt = lph_pkg::ST_NEW;
        end else if (rd_r == {1'b0, job_r.key}) begin
          st_nxt = lph_pkg::ST_DUP;
        end else if (left_r == 11'd1) begin
          fail_nxt = 1'b1; st_nxt = lph_pkg::ST_FAIL; ps_nxt = '0;
        end else begin
          left_nxt = left_r - 11'd1;
          slot_nxt = (slot_r + 1'b1) & mask;
          state_nxt = lph_pkg::BE_PROBE;
        end
      end
      lph_pkg::BE_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = lph_pkg::BE_IDLE;
      end
      default: state_nxt = lph_pkg::BE_IDLE;
    endcase
  end

  assign out_valid  = ov_r;
  assign o_status   = st_r;
  assign o_slot     = ps_r;
  assign o_total    = cnt_r;
  assign o_contents = ct_r;
  assign o_failed   = fail_r;
  assign o_done     = dn_r;

  `LPH_ASSERT_NXT(a_fail_sticky, clk, rst_n, fail_r && !pop, fail_r)
  `LPH_ASSERT_IMP(a_no_pop_busy, clk, rst_n, pop, !ov_r)
  `LPH_ASSERT_IMP(a_cnt_zero_clear, clk, rst_n, ov_r && st_r == lph_pkg::ST_CLEAR, cnt_r == '0)
endmodule
